FILE: rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: antecedent implies consequent on the same edge.
`define GCPB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GCPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gcpb_pkg.sv
package gcpb_pkg;

  localparam int XY_W = 27;
  localparam int Z_W = 24;
  localparam int FRAC_BITS = 16;
  localparam int INV_GAIN = 39797;
  localparam int HALF_PI = 1647099;
  localparam int MAX_BINS = 4096;
  localparam logic signed [7:0] MARK_VALUE = 8'sd100;

  typedef enum logic [1:0] {
    REG_CELL_SIZE  = 2'd0,
    REG_ANGLE_START = 2'd1,
    REG_BINS_PER_RAD = 2'd2,
    REG_NUM_BINS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        cell_size;
    logic signed [15:0] angle_start;
    logic [15:0]        bins_per_radian;
    logic [12:0]        num_bins;
  } cfg_t;

  typedef struct packed {
    logic                  mark;
    logic                  active;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [7:0]            value;
  } stage_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic signed [Z_W-1:0] atan_units(input int step);
    logic signed [Z_W-1:0] a;
    unique case (step)
      0: a = Z_W'(823550);
      1: a = Z_W'(486170);
      2: a = Z_W'(256879);
      3: a = Z_W'(130396);
      4: a = Z_W'(65451);
      5: a = Z_W'(32757);
      6: a = Z_W'(16383);
      7: a = Z_W'(8192);
      8: a = Z_W'(4096);
      9: a = Z_W'(2048);
      10: a = Z_W'(1024);
      11: a = Z_W'(512);
      12: a = Z_W'(256);
      13: a = Z_W'(128);
      14: a = Z_W'(64);
      15: a = Z_W'(32);
      16: a = Z_W'(16);
      17: a = Z_W'(8);
      18: a = Z_W'(4);
      19: a = Z_W'(2);
      20: a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/grid_cell_to_polar_bin.sv
// CORDIC_STEPS + 4 register stages lie between input accept and out_valid.
// Throughput: one word per cycle while out_stall is low; one entry stage,
// one CORDIC cell per step and three scaling stages, each with its own
// valid and stall.
// Stall ripples back from the output register only through full stages.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
`include "assert_macros.svh"

module grid_cell_to_polar_bin #(
  parameter int WINDOW_HALF = 25,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] offset_x,
  input  logic signed [7:0] offset_y,
  input  logic signed [7:0] cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] local_value,
  output logic              is_mark,
  output logic              bin_valid,
  output logic [11:0]       bin_index,
  output logic [23:0]       range_out
);
  import gcpb_pkg::*;

  cfg_t cfg;
  stage_t chain_word [0:CORDIC_STEPS];
  logic chain_valid [0:CORDIC_STEPS];
  logic chain_stall [0:CORDIC_STEPS];
  logic [7:0] value_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size <= 16'd6554;
      cfg.angle_start <= 16'hB488;
      cfg.bins_per_radian <= 16'd58617;
      cfg.num_bins <= 13'd1081;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_SIZE:    cfg.cell_size <= cfg_data;
        REG_ANGLE_START:  cfg.angle_start <= cfg_data;
        REG_BINS_PER_RAD: cfg.bins_per_radian <= cfg_data;
        REG_NUM_BINS:     cfg.num_bins <= cfg_data[12:0];
      endcase
    end
  end

  gcpb_entry #(.WINDOW_HALF(WINDOW_HALF)) u_entry (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .cell_value (cell_value),
    .down_valid (chain_valid[0]),
    .down_word  (chain_word[0]),
    .down_stall (chain_stall[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    gcpb_cell #(.STEP(k)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[k]),
      .up_stall   (chain_stall[k]),
      .up_word    (chain_word[k]),
      .down_valid (chain_valid[k+1]),
      .down_word  (chain_word[k+1]),
      .down_stall (chain_stall[k+1])
    );
  end

  gcpb_post u_post (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (chain_valid[CORDIC_STEPS]),
    .up_stall    (chain_stall[CORDIC_STEPS]),
    .up_word     (chain_word[CORDIC_STEPS]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .local_value (value_out),
    .is_mark     (is_mark),
    .bin_valid   (bin_valid),
    .bin_index   (bin_index),
    .range_out   (range_out)
  );

  assign local_value = value_out;

  `GCPB_ASSERT_NOW(a_nomark_quiet, clk, rst, out_valid && !is_mark, !bin_valid && bin_index == 12'd0 && range_out == 24'd0, "non-mark word carries bin or range")
  `GCPB_ASSERT_NOW(a_bin_in_range, clk, rst, out_valid && bin_valid, is_mark && 13'(bin_index) < cfg.num_bins, "valid bin outside scan")
  `GCPB_ASSERT_NOW(a_stall_source, clk, rst, in_stall, out_valid && out_stall, "input stalled without output backpressure")

endmodule

FILE: rtl/gcpb_entry.sv
module gcpb_entry #(
  parameter int WINDOW_HALF = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [7:0]   offset_x,
  input  logic signed [7:0]   offset_y,
  input  logic signed [7:0]   cell_value,
  output logic                down_valid,
  output gcpb_pkg::stage_t    down_word,
  input  logic                down_stall
);
  import gcpb_pkg::*;

  localparam logic signed [8:0] WIN_LO = 9'(-WINDOW_HALF);
  localparam logic signed [8:0] WIN_HI = 9'(WINDOW_HALF - 1);

  logic signed [8:0] dx9;
  logic signed [8:0] dy9;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic in_window;
  stage_t word_next;

  assign dx9 = {offset_x[7], offset_x};
  assign dy9 = {offset_y[7], offset_y};
  assign in_window = dx9 >= WIN_LO && dx9 <= WIN_HI && dy9 >= WIN_LO && dy9 <= WIN_HI;
  assign xs = {{(XY_W-8-FRAC_BITS){offset_x[7]}}, offset_x, {FRAC_BITS{1'b0}}};
  assign ys = {{(XY_W-8-FRAC_BITS){offset_y[7]}}, offset_y, {FRAC_BITS{1'b0}}};

  always_comb begin
    word_next = '0;
    word_next.value = cell_value;
    word_next.mark = in_window && cell_value == MARK_VALUE;
    word_next.active = word_next.mark && (offset_x != '0 || offset_y != '0);
    if (word_next.active) begin
      if (!offset_x[7]) begin
        word_next.x = xs;
        word_next.y = ys;
        word_next.z = '0;
      end else if (!offset_y[7]) begin
        word_next.x = ys;
        word_next.y = -xs;
        word_next.z = Z_W'(HALF_PI);
      end else begin
        word_next.x = -ys;
        word_next.y = xs;
        word_next.z = -Z_W'(HALF_PI);
      end
    end
  end

  assign in_stall = down_valid && down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (!in_stall) begin
      down_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      down_word <= word_next;
    end
  end

endmodule

FILE: rtl/gcpb_cell.sv
module gcpb_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_stall,
  input  gcpb_pkg::stage_t up_word,
  output logic             down_valid,
  output gcpb_pkg::stage_t down_word,
  input  logic             down_stall
);
  import gcpb_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = atan_units(STEP);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  stage_t word_next;

  assign xs = up_word.x >>> STEP;
  assign ys = up_word.y >>> STEP;

  always_comb begin
    word_next = up_word;
    if (up_word.active) begin
      if (!up_word.y[XY_W-1]) begin
        word_next.x = up_word.x + ys;
        word_next.y = up_word.y - xs;
        word_next.z = up_word.z + ANG;
      end else begin
        word_next.x = up_word.x - ys;
        word_next.y = up_word.y + xs;
        word_next.z = up_word.z - ANG;
      end
    end
  end

  assign up_stall = down_valid && down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (!up_stall) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      down_word <= word_next;
    end
  end

endmodule

FILE: rtl/gcpb_post.sv
module gcpb_post (
  input  logic             clk,
  input  logic             rst,
  input  gcpb_pkg::cfg_t   cfg,
  input  logic             up_valid,
  output logic             up_stall,
  input  gcpb_pkg::stage_t up_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       local_value,
  output logic             is_mark,
  output logic             bin_valid,
  output logic [11:0]      bin_index,
  output logic [23:0]      range_out
);
  import gcpb_pkg::*;

  localparam int D_W = Z_W + 1;
  localparam int PROD_W = D_W + 17;
  localparam int BIN_SHIFT = 28;
  localparam int BIN_W = PROD_W - BIN_SHIFT;
  localparam int R1_W = XY_W - 1 + 16;
  localparam int R2_W = R1_W + 16;
  localparam int RS_W = R2_W + 1 - 32;

  logic signed [D_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic x_pos;
  logic [R1_W-1:0] r1_next;
  logic [12:0] limit;
  logic [R2_W:0] rsum;
  logic [RS_W-1:0] rs;

  logic vld1, vld2;
  logic st1, st2, st3;
  logic [7:0] val1, val2;
  logic mark1, mark2;
  logic signed [BIN_W-1:0] bin1;
  logic [R1_W-1:0] r1;
  logic bv2;
  logic [11:0] idx2;
  logic [R2_W-1:0] r2;

  assign diff = {{(D_W-Z_W){up_word.z[Z_W-1]}}, up_word.z}
              - {{(D_W-23){cfg.angle_start[15]}}, cfg.angle_start, 7'b0};
  assign prod = PROD_W'(diff) * $signed({1'b0, cfg.bins_per_radian});
  assign x_pos = !up_word.x[XY_W-1] && up_word.x != '0;
  assign r1_next = x_pos ? R1_W'(up_word.x[XY_W-2:0]) * R1_W'(INV_GAIN) : '0;
  assign limit = cfg.num_bins > 13'(MAX_BINS) ? 13'(MAX_BINS) : cfg.num_bins;
  assign rsum = {1'b0, r2} + (R2_W+1)'(33'h080000000);
  assign rs = rsum[R2_W:32];

  assign st3 = out_valid && out_stall;
  assign st2 = vld2 && st3;
  assign st1 = vld1 && st2;
  assign up_stall = st1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!st1) vld1 <= up_valid;
      if (!st2) vld2 <= vld1;
      if (!st3) out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (!st1) begin
      val1 <= up_word.value;
      mark1 <= up_word.mark;
      bin1 <= prod[PROD_W-1:BIN_SHIFT];
      r1 <= r1_next;
    end
    if (!st2) begin
      val2 <= val1;
      mark2 <= mark1;
      bv2 <= mark1 && !bin1[BIN_W-1] && bin1[12:0] < limit;
      idx2 <= (mark1 && !bin1[BIN_W-1] && bin1[12:0] < limit) ? bin1[11:0] : '0;
      r2 <= r1 * R1_W'(cfg.cell_size);
    end
    if (!st3) begin
      local_value <= val2;
      is_mark <= mark2;
      bin_valid <= bv2;
      bin_index <= idx2;
      range_out <= (rs[RS_W-1:24] != '0) ? 24'hFFFFFF : rs[23:0];
    end
  end

endmodule

FILE: dv/tb_grid_cell_to_polar_bin.sv
`timescale 1ns / 1ps

module tb_grid_cell_to_polar_bin;
  import gcpb_pkg::*;

  localparam int WIN = 25;
  localparam int STEPS = 16;
  localparam int N_ROWS = 25;
  localparam int LONG_HOLD = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic signed [7:0] local_value;
    logic              is_mark;
    logic              bin_valid;
    logic [11:0]       bin_index;
    logic [23:0]       range_out;
  } polar_word_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] v;
    logic              typed;
    polar_word_t       word;
  } cell_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic signed [7:0] offset_x;
  logic signed [7:0] offset_y;
  logic signed [7:0] cell_value;
  logic              out_valid;
  logic              out_stall;
  logic signed [7:0] local_value;
  logic              is_mark;
  logic              bin_valid;
  logic [11:0]       bin_index;
  logic [23:0]       range_out;

  grid_cell_to_polar_bin #(
    .WINDOW_HALF(WIN),
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .cell_value(cell_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .local_value(local_value),
    .is_mark(is_mark),
    .bin_valid(bin_valid),
    .bin_index(bin_index),
    .range_out(range_out)
  );

  always #4 clk = ~clk;

  longint atan_tab [0:23] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  // directed cells; typed rows carry the expected word, the rest use the predictor
  cell_row_t stim_rows [0:N_ROWS-1] = '{
    '{8'sd0, 8'sd0, 8'sd100, 1'b1, '{8'sd100, 1'b1, 1'b1, 12'd540, 24'd0}},
    '{8'sd0, 8'sd0, 8'sd0, 1'b1, '{8'sd0, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{-8'sd128, -8'sd128, -8'sd128, 1'b1, '{-8'sd128, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd127, 8'sd127, 8'sd127, 1'b1, '{8'sd127, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd127, 8'sd0, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{-8'sd128, 8'sd5, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd25, 8'sd0, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{-8'sd26, 8'sd0, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd0, 8'sd25, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd0, -8'sd26, 8'sd100, 1'b1, '{8'sd100, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd3, 8'sd4, 8'sd99, 1'b1, '{8'sd99, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd3, 8'sd4, 8'sd101, 1'b1, '{8'sd101, 1'b0, 1'b0, 12'd0, 24'd0}},
    '{8'sd24, 8'sd0, 8'sd100, 1'b0, '0},
    '{-8'sd25, 8'sd0, 8'sd100, 1'b0, '0},
    '{8'sd0, 8'sd24, 8'sd100, 1'b0, '0},
    '{8'sd0, -8'sd25, 8'sd100, 1'b0, '0},
    '{8'sd24, 8'sd24, 8'sd100, 1'b0, '0},
    '{-8'sd25, -8'sd25, 8'sd100, 1'b0, '0},
    '{-8'sd25, 8'sd24, 8'sd100, 1'b0, '0},
    '{8'sd24, -8'sd25, 8'sd100, 1'b0, '0},
    '{8'sd1, 8'sd0, 8'sd100, 1'b0, '0},
    '{-8'sd1, 8'sd0, 8'sd100, 1'b0, '0},
    '{8'sd0, -8'sd1, 8'sd100, 1'b0, '0},
    '{-8'sd1, -8'sd1, 8'sd100, 1'b0, '0},
    '{8'sd5, -8'sd3, 8'sd100, 1'b0, '0}
  };

  cfg_t        shadow_cfg;
  polar_word_t pending_polar [$];
  polar_word_t row_word;
  logic        row_typed;
  polar_word_t got_word;
  polar_word_t want_word;
  int          mismatch_count = 0;
  int          word_count = 0;
  int          cycle_count = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_pending = 0;
  int          hold_served = 0;

  function automatic polar_word_t predict_polar(input logic signed [7:0] dx,
                                                input logic signed [7:0] dy,
                                                input logic signed [7:0] val);
    polar_word_t r;
    longint x, y, z, xs, ys, t, diff, bin, lim;
    longint unsigned rng;
    logic in_window;
    r = '0;
    r.local_value = val;
    in_window = dx >= -WIN && dx <= WIN - 1 && dy >= -WIN && dy <= WIN - 1;
    r.is_mark = in_window && val == MARK_VALUE;
    if (r.is_mark) begin
      x = longint'(dx) <<< FRAC_BITS;
      y = longint'(dy) <<< FRAC_BITS;
      z = 0;
      if (dx != 0 || dy != 0) begin
        if (dx < 0) begin
          t = x;
          if (dy >= 0) begin
            x = y;
            y = -t;
            z = HALF_PI;
          end else begin
            x = -y;
            y = t;
            z = -HALF_PI;
          end
        end
        for (int i = 0; i < STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_tab[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_tab[i];
          end
        end
        if (x > 0) begin
          rng = longint'(x) * longint'(INV_GAIN);
          rng = (rng * longint'(shadow_cfg.cell_size) + 64'd2147483648) >> 32;
          r.range_out = (rng > 64'd16777215) ? 24'hFFFFFF : rng[23:0];
        end
      end
      diff = z - longint'(shadow_cfg.angle_start) * 128;
      bin = (diff * longint'(shadow_cfg.bins_per_radian)) >>> 28;
      lim = (shadow_cfg.num_bins > MAX_BINS) ? MAX_BINS : longint'(shadow_cfg.num_bins);
      if (bin >= 0 && bin < lim) begin
        r.bin_valid = 1'b1;
        r.bin_index = bin[11:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH word %0d: %s", word_count, what);
    mismatch_count++;
  endtask

  // output check first, then capture of the accepted input
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_cell_to_polar_bin test failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got_word = '{local_value, is_mark, bin_valid, bin_index, range_out};
      if (pending_polar.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        want_word = pending_polar.pop_front();
        if (got_word.local_value !== want_word.local_value)
          report_mismatch($sformatf("local_value %0d exp %0d",
                                    got_word.local_value, want_word.local_value));
        if (got_word.is_mark !== want_word.is_mark)
          report_mismatch($sformatf("is_mark %b exp %b",
                                    got_word.is_mark, want_word.is_mark));
        if (got_word.bin_valid !== want_word.bin_valid)
          report_mismatch($sformatf("bin_valid %b exp %b",
                                    got_word.bin_valid, want_word.bin_valid));
        if (got_word.bin_index !== want_word.bin_index)
          report_mismatch($sformatf("bin_index %0d exp %0d",
                                    got_word.bin_index, want_word.bin_index));
        if (got_word.range_out !== want_word.range_out)
          report_mismatch($sformatf("range_out %0d exp %0d",
                                    got_word.range_out, want_word.range_out));
      end
      word_count++;
    end
    if (!rst && in_valid && !in_stall)
      pending_polar.push_back(row_typed ? row_word
                                        : predict_polar(offset_x, offset_y, cell_value));
  end

  // receiver stall; a requested long hold-off is served here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_pending) begin
        hold_served = hold_pending;
        repeat (LONG_HOLD) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = ($urandom_range(99) < snk_idle_pct);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_CELL_SIZE:    shadow_cfg.cell_size = data;
      REG_ANGLE_START:  shadow_cfg.angle_start = data;
      REG_BINS_PER_RAD: shadow_cfg.bins_per_radian = data;
      REG_NUM_BINS:     shadow_cfg.num_bins = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_regs(input logic [15:0] cs, input logic [15:0] ang,
                            input logic [15:0] bpr, input logic [15:0] nb);
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_ANGLE_START, ang);
    write_reg(REG_BINS_PER_RAD, bpr);
    write_reg(REG_NUM_BINS, nb);
  endtask

  task automatic send_cell(input logic signed [7:0] x, input logic signed [7:0] y,
                           input logic signed [7:0] v, input logic typed,
                           input polar_word_t word);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    offset_x = x;
    offset_y = y;
    cell_value = v;
    row_typed = typed;
    row_word = word;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int sel;
    logic signed [7:0] x, y, v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      x = 8'(int'($urandom_range(2 * WIN - 1)) - WIN);
      y = 8'(int'($urandom_range(2 * WIN - 1)) - WIN);
      v = MARK_VALUE;
    end else if (sel < 75) begin
      x = 8'($urandom);
      y = 8'($urandom);
      v = MARK_VALUE;
    end else begin
      x = 8'($urandom);
      y = 8'($urandom);
      v = 8'($urandom);
    end
    send_cell(x, y, v, 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending_polar.size() != 0) @(negedge clk);
    repeat (STEPS + 8) @(negedge clk);
  endtask

  task automatic run_phase(input int n_items);
    repeat (n_items) send_random();
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    offset_x = '0;
    offset_y = '0;
    cell_value = '0;
    row_typed = 1'b0;
    row_word = '0;
    shadow_cfg = '{16'd6554, -16'sd19320, 16'd58617, 13'd1081};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 14;
    snk_idle_pct = 74;
    for (int r = 0; r < N_ROWS; r++)
      send_cell(stim_rows[r].x, stim_rows[r].y, stim_rows[r].v,
                stim_rows[r].typed, stim_rows[r].word);
    wait_drain();

    write_regs(16'd65535, 16'(-25736), 16'd65535, 16'd4096);
    repeat (20) send_random();
    hold_pending++;
    run_phase(100);

    write_regs(16'd1, 16'd25736, 16'd1, 16'd1);
    run_phase(100);

    src_idle_pct = 74;
    snk_idle_pct = 14;
    write_regs(16'd0, 16'h8000, 16'd0, 16'd0);
    run_phase(100);

    write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'd8191);
    run_phase(100);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_regs(16'($urandom_range(65535, 1)), 16'(int'($urandom_range(51472)) - 25736),
               16'($urandom_range(65535, 1)), 16'($urandom_range(4096, 1)));
    run_phase(100);

    write_regs(16'd6554, 16'(-19320), 16'd58617, 16'd1081);
    run_phase(100);

    if (mismatch_count == 0)
      $display("grid_cell_to_polar_bin test passed");
    else
      $display("grid_cell_to_polar_bin test failed");
    $finish;
  end

endmodule
